// File: src/salcp_pkg.sv
// Shared types and constants for the suffix array / LCP builder.
// Used by the controller, the datapath and the top level.
package salcp_pkg;

    localparam int MAX_LEN_DEF  = 1024;
    localparam int ALPHABET_DEF = 1024;
    localparam int SYM_W        = 10;
    localparam int IDX_W        = 10;
    localparam int LEN_W        = 11;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT,     // rank = sym+1, prev = rank, scratch = i
        S_COPY,     // prev = rank, scratch = i
        S_CLR,      // clear buckets
        S_CNT,      // count keys
        S_PFX,      // prefix sum
        S_PLACE,    // backward placement
        S_MOVE,     // suffix_order = scratch
        S_RANK,     // re-rank
        S_LCP,      // Kasai scan
        S_RESP,
        S_OUT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        state_t phase;
        logic   first;   // first cycle of a phase
        logic   pass2;   // second counting pass (offset 0, src order)
        logic   do_load;
        logic   do_read;
        logic   start;   // last load that needs no sort rounds (sets up n == 1)
    } cmd_t;

    typedef struct packed {
        logic phase_done;
        logic more_rounds;
        logic trivial;   // n <= 1
    } sts_t;

endpackage

// File: src/salcp_datapath.sv
// Datapath: text, rank, prev, order, scratch, bucket and LCP memories plus sweep counters.
// Depends on salcp_pkg; driven by salcp_ctrl.
module salcp_datapath
    import salcp_pkg::*;
#(
    parameter int MAX_LEN  = MAX_LEN_DEF,
    parameter int ALPHABET = ALPHABET_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    output sts_t             sts,
    input  logic [SYM_W-1:0] in_symbol,
    input  logic             in_last,
    input  logic [IDX_W-1:0] in_index,
    output logic [IDX_W-1:0] res_start,
    output logic [IDX_W-1:0] res_lcp,
    output logic [LEN_W-1:0] res_len,
    output logic [1:0]       res_status,
    output logic             load_last
);
    localparam int AW    = $clog2(MAX_LEN);
    localparam int NW    = $clog2(MAX_LEN + 1);
    localparam int RW    = $clog2(ALPHABET + MAX_LEN + 2);
    localparam int SLOTS = ALPHABET + MAX_LEN + 2;
    localparam int KW    = $clog2(SLOTS);
    localparam int SW    = $clog2(ALPHABET);

    logic [SW-1:0] text_mem    [MAX_LEN];
    logic [AW-1:0] order_mem   [MAX_LEN];
    logic [AW-1:0] scratch_mem [MAX_LEN];
    logic [RW-1:0] rank_mem    [MAX_LEN];
    logic [RW-1:0] prev_mem    [MAX_LEN];
    logic [IDX_W-1:0] lcp_mem  [MAX_LEN];
    logic [NW-1:0] bucket_mem  [SLOTS];

    logic [NW-1:0] len_reg, len_next;
    logic          built_reg;
    logic [NW:0]   k_reg;       // doubling offset
    logic [NW:0]   i_reg;       // sweep index
    logic [2:0]    sub_reg;     // step within an element
    logic [NW-1:0] acc_reg;     // prefix accumulator / rank counter
    logic [NW-1:0] h_reg;
    logic [AW-1:0] p_reg, s_reg, t_reg, j_reg;
    logic [RW-1:0] ra_reg, rb_reg, ka_reg;
    logic [KW-1:0] key_reg;
    logic [SW-1:0] ca_reg, cb_reg;
    logic          last_reg;
    logic [IDX_W-1:0] ostart_reg, olcp_reg;
    logic [1:0]       ostat_reg;
    logic [NW-1:0]    cnt_reg;
    logic [IDX_W-1:0] idx_reg;  // read index held for the response
    logic             done;

    // synchronous reads
    logic [AW-1:0] a_order, a_scr, a_rank, a_prev, a_text;
    logic [KW-1:0] a_bkt;
    logic [AW-1:0] d_order, d_scr;
    logic [RW-1:0] d_rank, d_prev;
    logic [SW-1:0] d_text;
    logic [NW-1:0] d_bkt;

    logic [NW:0] n_ext;
    assign n_ext = {1'b0, len_reg};

    assign sts.phase_done  = done;
    assign sts.more_rounds = (k_reg < n_ext);
    assign sts.trivial     = (len_reg <= NW'(1));
    assign res_start  = ostart_reg;
    assign res_lcp    = olcp_reg;
    assign res_len    = LEN_W'(len_reg);
    assign res_status = ostat_reg;
    assign load_last  = last_reg;

    logic [SW-1:0] sym_sat;
    assign sym_sat = (32'(in_symbol) >= ALPHABET) ? SW'(ALPHABET - 1) : SW'(in_symbol);

    always_ff @(posedge clk)
    begin
        d_order <= order_mem[a_order];
        d_scr   <= scratch_mem[a_scr];
        d_rank  <= rank_mem[a_rank];
        d_prev  <= prev_mem[a_prev];
        d_text  <= text_mem[a_text];
        d_bkt   <= bucket_mem[a_bkt];
    end

    // Address selection per phase/substep
    always_comb
    begin
        a_order = i_reg[AW-1:0];
        a_scr   = i_reg[AW-1:0];
        a_rank  = i_reg[AW-1:0];
        a_prev  = i_reg[AW-1:0];
        a_text  = i_reg[AW-1:0];
        a_bkt   = key_reg;
        case (cmd.phase)
            S_CNT, S_PLACE:
            begin
                a_order = (i_reg - 1'b1) >> 0 == 0 ? AW'(0) : AW'(i_reg - 1'b1);
                a_scr   = a_order;
                if (cmd.phase == S_CNT)
                begin
                    a_order = i_reg[AW-1:0];
                    a_scr   = i_reg[AW-1:0];
                end
                // first pass keys on the rank at offset k, second on the rank itself
                a_prev  = cmd.pass2 ? p_reg : AW'(32'(p_reg) + 32'(k_reg));
            end
            S_PFX: a_bkt = KW'(i_reg);
            S_RANK:
            begin
                a_order = (sub_reg == 3'd0) ? i_reg[AW-1:0] : AW'(i_reg + 1'b1);
                a_prev  = (sub_reg == 3'd2) ? s_reg :
                          (sub_reg == 3'd3) ? t_reg :
                          (sub_reg == 3'd4) ? AW'(32'(s_reg) + 32'(k_reg)) :
                                              AW'(32'(t_reg) + 32'(k_reg));
            end
            S_LCP:
            begin
                a_order = AW'(32'(acc_reg) - 2);
                a_text  = (sub_reg[0]) ? AW'(32'(j_reg) + 32'(h_reg))
                                       : AW'(32'(i_reg) + 32'(h_reg));
            end
            S_RESP: a_order = idx_reg[AW-1:0];
            default: ;
        endcase
    end

    logic [NW:0] ih, jh;
    assign ih = NW'(i_reg) + (NW+1)'(h_reg);
    assign jh = (NW+1)'(j_reg) + (NW+1)'(h_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            built_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            len_reg <= len_next;
            if (cmd.do_load)
            begin
                last_reg <= in_last;
                built_reg <= in_last;
            end
        end
    end

    always_comb
    begin
        len_next = len_reg;
        if (cmd.do_load)
        begin
            len_next = built_reg ? NW'(0) : len_reg;
            if (32'(len_next) < MAX_LEN)
                len_next = len_next + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        done <= 1'b0;
        if (cmd.do_load)
        begin
            ostart_reg <= '0;
            olcp_reg   <= '0;
            ostat_reg  <= ST_OK;
            if (32'(built_reg ? NW'(0) : len_reg) < MAX_LEN)
                text_mem[(built_reg ? AW'(0) : len_reg[AW-1:0])] <= sym_sat;
            else
                ostat_reg <= ST_OVERFLOW;
        end
        if (cmd.do_read)
        begin
            ostart_reg <= '0;
            olcp_reg   <= '0;
            ostat_reg  <= ST_RANGE;
            cnt_reg    <= NW'(0);
            idx_reg    <= in_index;
            if (built_reg && (NW+1)'(in_index) < n_ext && 32'(in_index) < MAX_LEN)
                ostat_reg <= ST_OK;
        end
        if (cmd.first)
        begin
            i_reg   <= '0;
            sub_reg <= '0;
            acc_reg <= '0;
            h_reg   <= '0;
            if (cmd.phase == S_INIT) k_reg <= (NW+1)'(1);
            if (cmd.phase == S_PLACE) i_reg <= n_ext;
            if (cmd.phase == S_RANK) acc_reg <= NW'(1);
            // the smallest suffix has no predecessor
            if (cmd.phase == S_LCP) lcp_mem[0] <= '0;
        end
        else
        begin
            case (cmd.phase)
                S_INIT, S_COPY:
                begin
                    // read, then write
                    if (sub_reg == 3'd0) sub_reg <= 3'd1;
                    else
                    begin
                        if (cmd.phase == S_INIT)
                        begin
                            rank_mem[i_reg[AW-1:0]] <= RW'(d_text) + 1'b1;
                            prev_mem[i_reg[AW-1:0]] <= RW'(d_text) + 1'b1;
                        end
                        else
                            prev_mem[i_reg[AW-1:0]] <= d_rank;
                        scratch_mem[i_reg[AW-1:0]] <= i_reg[AW-1:0];
                        sub_reg <= 3'd0;
                        i_reg   <= i_reg + 1'b1;
                        if (i_reg + 1'b1 == n_ext) done <= 1'b1;
                    end
                end
                S_CLR:
                begin
                    bucket_mem[KW'(i_reg)] <= '0;
                    i_reg <= i_reg + 1'b1;
                    if (32'(i_reg) == SLOTS - 1) done <= 1'b1;
                end
                S_CNT, S_PLACE:
                begin
                    case (sub_reg)
                        3'd0: sub_reg <= 3'd1;  // src read
                        3'd1:
                        begin
                            p_reg   <= cmd.pass2 ? d_order : d_scr;
                            sub_reg <= 3'd2;
                        end
                        3'd2: sub_reg <= 3'd3;  // prev read (addr uses p)
                        3'd3:
                        begin
                            if (!cmd.pass2 &&
                                (32'(p_reg) + 32'(k_reg)) >= 32'(len_reg))
                                key_reg <= '0;
                            else
                                key_reg <= KW'(d_prev);
                            sub_reg <= 3'd4;
                        end
                        3'd4: sub_reg <= 3'd5;  // bucket read
                        default:
                        begin
                            sub_reg <= 3'd0;
                            if (cmd.phase == S_CNT)
                            begin
                                bucket_mem[key_reg] <= d_bkt + 1'b1;
                                i_reg <= i_reg + 1'b1;
                                if (i_reg + 1'b1 == n_ext) done <= 1'b1;
                            end
                            else
                            begin
                                bucket_mem[key_reg] <= d_bkt - 1'b1;
                                if (cmd.pass2)
                                    scratch_mem[AW'(d_bkt - 1'b1)] <= p_reg;
                                else
                                    order_mem[AW'(d_bkt - 1'b1)] <= p_reg;
                                i_reg <= i_reg - 1'b1;
                                if (i_reg == (NW+1)'(1)) done <= 1'b1;
                            end
                        end
                    endcase
                end
                S_PFX:
                begin
                    if (sub_reg == 3'd0) sub_reg <= 3'd1;
                    else
                    begin
                        bucket_mem[KW'(i_reg)] <= d_bkt + acc_reg;
                        acc_reg <= d_bkt + acc_reg;
                        sub_reg <= 3'd0;
                        i_reg <= i_reg + 1'b1;
                        if (32'(i_reg) == SLOTS - 1) done <= 1'b1;
                    end
                end
                S_MOVE:
                begin
                    if (sub_reg == 3'd0) sub_reg <= 3'd1;
                    else
                    begin
                        order_mem[i_reg[AW-1:0]] <= d_scr;
                        sub_reg <= 3'd0;
                        i_reg <= i_reg + 1'b1;
                        if (i_reg + 1'b1 == n_ext) done <= 1'b1;
                    end
                end
                S_RANK:
                begin
                    case (sub_reg)
                        3'd0: sub_reg <= 3'd1;
                        3'd1:
                        begin
                            s_reg <= d_order;
                            rank_mem[d_order] <= RW'(acc_reg);
                            sub_reg <= 3'd2;
                            if (i_reg + 1'b1 == n_ext)
                            begin
                                done  <= 1'b1;
                                k_reg <= k_reg << 1;
                                sub_reg <= 3'd0;
                            end
                        end
                        3'd2:
                        begin
                            t_reg <= d_order;
                            sub_reg <= 3'd3;
                        end
                        3'd3:
                        begin
                            ra_reg <= d_prev;
                            sub_reg <= 3'd4;
                        end
                        3'd4:
                        begin
                            rb_reg <= d_prev;
                            sub_reg <= 3'd5;
                        end
                        3'd5:
                        begin
                            ka_reg <= ((32'(s_reg) + 32'(k_reg)) < 32'(len_reg)) ? d_prev : '0;
                            sub_reg <= 3'd6;
                        end
                        default:
                        begin
                            if (ra_reg != rb_reg || ka_reg !=
                                (((32'(t_reg) + 32'(k_reg)) < 32'(len_reg)) ? d_prev : RW'(0)))
                                acc_reg <= acc_reg + 1'b1;
                            i_reg <= i_reg + 1'b1;
                            sub_reg <= 3'd0;
                        end
                    endcase
                end
                S_LCP:
                begin
                    case (sub_reg)
                        3'd0:
                        begin
                            if (h_reg != '0) h_reg <= h_reg - 1'b1;
                            sub_reg <= 3'd1;  // wait rank read
                        end
                        3'd1:
                        begin
                            acc_reg <= NW'(d_rank);
                            if (d_rank <= RW'(1) || d_rank > RW'(len_reg))
                            begin
                                h_reg <= '0;
                                sub_reg <= 3'd0;
                                i_reg <= i_reg + 1'b1;
                                if (i_reg + 1'b1 == n_ext) done <= 1'b1;
                            end
                            else sub_reg <= 3'd2;
                        end
                        3'd2: sub_reg <= 3'd3;   // order read at r-2
                        3'd3:
                        begin
                            j_reg <= d_order;
                            sub_reg <= 3'd4;
                        end
                        3'd4: sub_reg <= 3'd5;   // text[i+h] read
                        3'd5:
                        begin
                            ca_reg <= d_text;
                            sub_reg <= 3'd6;     // text[j+h] read
                        end
                        3'd6:
                        begin
                            cb_reg <= d_text;
                            sub_reg <= 3'd7;
                        end
                        default:
                        begin
                            if (ih < n_ext && jh < n_ext && ca_reg == cb_reg)
                            begin
                                h_reg <= h_reg + 1'b1;
                                sub_reg <= 3'd4;
                            end
                            else
                            begin
                                lcp_mem[AW'(acc_reg - 1'b1)] <= IDX_W'(h_reg);
                                sub_reg <= 3'd0;
                                i_reg <= i_reg + 1'b1;
                                if (i_reg + 1'b1 == n_ext) done <= 1'b1;
                            end
                        end
                    endcase
                end
                S_IDLE:
                begin
                    if (cmd.start && len_reg == NW'(1))
                    begin
                        order_mem[0] <= '0;
                        rank_mem[0]  <= RW'(1);
                        lcp_mem[0]   <= '0;
                    end
                end
                S_RESP:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == NW'(1))
                    begin
                        if (ostat_reg == ST_OK)
                        begin
                            ostart_reg <= d_order;
                            olcp_reg   <= lcp_mem[idx_reg[AW-1:0]];
                        end
                        done <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(len_reg) <= MAX_LEN) else $error("length past capacity");
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.do_load) && ostat_reg == ST_OVERFLOW |-> 32'(len_reg) == MAX_LEN)
        else $error("overflow while not full");
    a_load_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_load && !built_reg && 32'(len_reg) < MAX_LEN |=> len_reg == $past(len_reg) + 1'b1)
        else $error("load did not grow text");
`endif
endmodule

// File: src/salcp_ctrl.sv
// Construction and request sequencer.
// Depends on salcp_pkg; commands salcp_datapath.
module salcp_ctrl
    import salcp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic in_op,
    input  logic load_last,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);
    state_t state_reg, state_next;
    logic   first_reg, first_next;
    logic   pass2_reg, pass2_next;
    logic   ovalid_reg, ovalid_next;
    logic   acc;

    assign out_valid = ovalid_reg;
    assign in_ready  = (state_reg == S_IDLE) && !ovalid_reg;
    assign acc       = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            first_reg  <= 1'b0;
            pass2_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            first_reg  <= first_next;
            pass2_reg  <= pass2_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        first_next  = 1'b0;
        pass2_next  = pass2_reg;
        ovalid_next = ovalid_reg && !out_ready;
        cmd.phase   = state_reg;
        cmd.first   = first_reg;
        cmd.pass2   = pass2_reg;
        cmd.do_load = acc && (in_op == OP_LOAD);
        cmd.do_read = acc && (in_op == OP_READ);
        cmd.start   = 1'b0;
        case (state_reg)
            S_IDLE:
                if (acc)
                begin
                    state_next = (in_op == OP_READ) ? S_RESP : S_OUT;
                    first_next = 1'b1;
                end
            S_OUT:
            begin
                // datapath now holds the post-load length
                if (load_last && !sts.trivial)
                begin
                    state_next = S_INIT;
                    first_next = 1'b1;
                end
                else
                begin
                    cmd.phase  = S_IDLE;
                    cmd.first  = 1'b0;
                    cmd.start  = load_last;
                    state_next = S_IDLE;
                    ovalid_next = 1'b1;
                end
            end
            S_RESP:
                if (sts.phase_done)
                begin
                    state_next  = S_IDLE;
                    ovalid_next = 1'b1;
                end
            S_INIT, S_COPY:
                if (sts.phase_done)
                begin
                    state_next = S_CLR;
                    pass2_next = 1'b0;
                    first_next = 1'b1;
                end
            S_CLR:
                if (sts.phase_done) begin state_next = S_CNT; first_next = 1'b1; end
            S_CNT:
                if (sts.phase_done) begin state_next = S_PFX; first_next = 1'b1; end
            S_PFX:
                if (sts.phase_done) begin state_next = S_PLACE; first_next = 1'b1; end
            S_PLACE:
                if (sts.phase_done)
                begin
                    first_next = 1'b1;
                    if (pass2_reg) state_next = S_MOVE;
                    else
                    begin
                        pass2_next = 1'b1;
                        state_next = S_CLR;
                    end
                end
            S_MOVE:
                if (sts.phase_done) begin state_next = S_RANK; first_next = 1'b1; end
            S_RANK:
                if (sts.phase_done)
                begin
                    first_next = 1'b1;
                    state_next = sts.more_rounds ? S_COPY : S_LCP;
                end
            S_LCP:
                if (sts.phase_done)
                begin
                    state_next  = S_IDLE;
                    ovalid_next = 1'b1;
                end
            default: state_next = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("accepted with result pending");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> !out_valid) else $error("result too early");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result lost");
`endif
endmodule

// File: src/suffix_array_lcp_builder_top.sv
// Suffix array + LCP builder, one item at a time: a new load or read is accepted
// only after the previous result has been taken. A load marked last with n > 1
// first runs ceil(log2(n)) doubling rounds, then a Kasai scan.
// Reset (rst_n, async low) empties the text; memories are not cleared.
module suffix_array_lcp_builder_top
    import salcp_pkg::*;
#(
    parameter int MAX_LEN  = MAX_LEN_DEF,
    parameter int ALPHABET = ALPHABET_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // symbol[9:0], sorted_index[19:10]
    input  logic        s_axis_tlast,
    input  logic        s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // suffix_start, lcp_prev, text_length, status
);
    cmd_t cmd;
    sts_t sts;
    logic [IDX_W-1:0] r_start, r_lcp;
    logic [LEN_W-1:0] r_len;
    logic [1:0]       r_stat;
    logic             ld_last;

    salcp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_op(s_axis_tuser), .load_last(ld_last),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .sts(sts), .cmd(cmd)
    );

    salcp_datapath #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .in_symbol(s_axis_tdata[9:0]), .in_last(s_axis_tlast),
        .in_index(s_axis_tdata[19:10]),
        .res_start(r_start), .res_lcp(r_lcp), .res_len(r_len),
        .res_status(r_stat), .load_last(ld_last)
    );

    assign m_axis_tdata = {7'd0, r_stat, r_len, r_lcp, r_start};
endmodule
